[src/complex_kernel_convolution_magnitude_macros.svh]
// Assertion macros for the file that carries checks.
`ifndef COMPLEX_KERNEL_CONVOLUTION_MAGNITUDE_MACROS_SVH
`define COMPLEX_KERNEL_CONVOLUTION_MAGNITUDE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CKCM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CKCM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/ckcm_pkg.sv]
package ckcm_pkg;

   localparam int MAX_COLS_DEF  = 256;
   localparam int MAX_ROWS_DEF  = 256;
   localparam int MAX_KSIDE_DEF = 15;

   // Depth of the queue between the front and the back part.
   localparam int QUEUE_DEPTH = 2;
   localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   // Image dimensions after saturation fit in this many bits (up to 8191).
   localparam int DIM_W = 13;
   localparam int ACC_W = 32;
   localparam int MAG_W = 17;
   localparam int CSR_IDX_W = 3;

   localparam logic [1:0] OP_COEF    = 2'd0;
   localparam logic [1:0] OP_PIXEL   = 2'd1;
   localparam logic [1:0] OP_REQUEST = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KHALF_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KHALF_HEIGHT = 3'd3;

   typedef enum logic [1:0] {
      KIND_COEF,
      KIND_PIXEL,
      KIND_REQ
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [7:0]         row;
      logic [7:0]         col;
      logic [7:0]         pixel;
      logic signed [15:0] coef_real;
      logic signed [15:0] coef_imag;
   } item_type;

   // Configuration as the datapath sees it, already saturated.
   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [2:0]       khw;
      logic [2:0]       khh;
   } cfg_type;

endpackage

[src/ckcm_front.sv]
module ckcm_front #(
   parameter int MAX_ROWS        = ckcm_pkg::MAX_ROWS_DEF,
   parameter int MAX_KERNEL_SIDE = ckcm_pkg::MAX_KSIDE_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          opcode,
   input  logic [7:0]          row,
   input  logic [7:0]          col,
   input  logic [7:0]          pixel,
   input  logic signed [15:0]  coef_real,
   input  logic signed [15:0]  coef_imag,
   input  ckcm_pkg::cfg_type   cfg,
   input  logic [ckcm_pkg::DIM_W-1:0] max_cols,
   output logic                head_valid,
   output ckcm_pkg::item_type  head,
   input  logic                pop
);

   ckcm_pkg::item_type entry_ff [ckcm_pkg::QUEUE_DEPTH];
   logic [ckcm_pkg::Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [ckcm_pkg::Q_CNT_W-1:0] count_ff, count_in;
   ckcm_pkg::kind_type kind;
   logic keep, push;

   // Sort the word: out-of-range writes, requests outside the image and
   // unknown opcodes are dropped here and never reach the back part.
   always_comb begin
      kind = ckcm_pkg::KIND_REQ;
      keep = 1'b0;
      case (opcode)
         ckcm_pkg::OP_COEF: begin
            kind = ckcm_pkg::KIND_COEF;
            keep = (ckcm_pkg::DIM_W'(row) < ckcm_pkg::DIM_W'(MAX_KERNEL_SIDE)) &&
                   (ckcm_pkg::DIM_W'(col) < ckcm_pkg::DIM_W'(MAX_KERNEL_SIDE));
         end
         ckcm_pkg::OP_PIXEL: begin
            kind = ckcm_pkg::KIND_PIXEL;
            keep = (ckcm_pkg::DIM_W'(row) < ckcm_pkg::DIM_W'(MAX_ROWS)) &&
                   (ckcm_pkg::DIM_W'(col) < max_cols);
         end
         ckcm_pkg::OP_REQUEST: begin
            kind = ckcm_pkg::KIND_REQ;
            keep = (ckcm_pkg::DIM_W'(row) < cfg.height) &&
                   (ckcm_pkg::DIM_W'(col) < cfg.width);
         end
         default: keep = 1'b0;
      endcase
   end

   assign busy       = (count_ff == ckcm_pkg::Q_CNT_W'(ckcm_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign push       = start && !busy && keep;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == ckcm_pkg::Q_PTR_W'(ckcm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == ckcm_pkg::Q_PTR_W'(ckcm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{kind: kind, row: row, col: col, pixel: pixel,
                                  coef_real: coef_real, coef_imag: coef_imag};
      end
   end

endmodule

[src/ckcm_back.sv]
module ckcm_back #(
   parameter int MAX_COLS        = ckcm_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS        = ckcm_pkg::MAX_ROWS_DEF,
   parameter int MAX_KERNEL_SIDE = ckcm_pkg::MAX_KSIDE_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ckcm_pkg::cfg_type   cfg,
   input  logic                head_valid,
   input  ckcm_pkg::item_type  head,
   output logic                pop,
   output logic                rsp_valid,
   output logic [ckcm_pkg::MAG_W-1:0] rsp_magnitude,
   output logic [7:0]          rsp_out_row,
   output logic [7:0]          rsp_out_col
);

   localparam int FDEPTH = MAX_ROWS * MAX_COLS;
   localparam int FAW    = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
   localparam int KDEPTH = MAX_KERNEL_SIDE * MAX_KERNEL_SIDE;
   localparam int KAW    = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
   localparam int DW     = ckcm_pkg::DIM_W;
   localparam int AW     = ckcm_pkg::ACC_W;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_TAP   = 6'b000010,
      ST_DRAIN = 6'b000100,
      ST_SQR   = 6'b001000,
      ST_SQI   = 6'b010000,
      ST_ROOT  = 6'b100000
   } state_type;

   logic [7:0]  fmem [FDEPTH];
   logic [31:0] kmem [KDEPTH];

   state_type state_ff, state_in;
   logic [3:0] kr_ff, kr_in, kc_ff, kc_in;
   logic [7:0] row_ff, row_in, col_ff, col_in;
   logic signed [AW-1:0] acc_r_ff, acc_r_in, acc_i_ff, acc_i_in;
   logic [63:0] rem_ff, rem_in, res_ff, res_in, bit_ff, bit_in;
   logic [4:0]  step_ff, step_in;
   logic        tap_en_ff, tap_en_in, tap_ok_ff, tap_ok_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [ckcm_pkg::MAG_W-1:0] mag_ff, mag_in;
   logic [7:0]  pix_ff;
   logic [31:0] kdata_ff;

   logic [DW:0] r_pos, c_pos;
   logic        tap_ok;
   logic [FAW-1:0] faddr_rd, faddr_wr;
   logic [KAW-1:0] kaddr_rd, kaddr_wr;
   logic        fmem_we, kmem_we;
   logic signed [24:0] prod_r, prod_i;
   logic [31:0] sq_op;
   logic [63:0] sq, trial, root_next;
   logic        ge;

   // Window tap position; bit DW set means it fell above or left of the image edge.
   assign r_pos  = (DW+1)'(row_ff) + (DW+1)'(kr_ff) - (DW+1)'(cfg.khh);
   assign c_pos  = (DW+1)'(col_ff) + (DW+1)'(kc_ff) - (DW+1)'(cfg.khw);
   assign tap_ok = !r_pos[DW] && (r_pos[DW-1:0] < cfg.height) &&
                   !c_pos[DW] && (c_pos[DW-1:0] < cfg.width);

   assign faddr_rd = FAW'(int'(r_pos[DW-1:0]) * MAX_COLS + int'(c_pos[DW-1:0]));
   assign kaddr_rd = KAW'(int'(kr_ff) * MAX_KERNEL_SIDE + int'(kc_ff));
   assign faddr_wr = FAW'(int'(head.row) * MAX_COLS + int'(head.col));
   assign kaddr_wr = KAW'(int'(head.row) * MAX_KERNEL_SIDE + int'(head.col));

   always_ff @(posedge clock) begin
      if (fmem_we) begin
         fmem[faddr_wr] <= head.pixel;
      end
      pix_ff <= fmem[faddr_rd];
   end

   always_ff @(posedge clock) begin
      if (kmem_we) begin
         kmem[kaddr_wr] <= {head.coef_imag, head.coef_real};
      end
      kdata_ff <= kmem[kaddr_rd];
   end

   assign prod_r = $signed({1'b0, pix_ff}) * $signed(kdata_ff[15:0]);
   assign prod_i = $signed({1'b0, pix_ff}) * $signed(kdata_ff[31:16]);

   // One shared squarer serves both parts of the sum.
   always_comb begin
      if (state_ff == ST_SQR) begin
         sq_op = acc_r_ff[AW-1] ? 32'(-acc_r_ff) : 32'(acc_r_ff);
      end else begin
         sq_op = acc_i_ff[AW-1] ? 32'(-acc_i_ff) : 32'(acc_i_ff);
      end
   end
   assign sq = 64'(sq_op) * 64'(sq_op);

   assign trial     = res_ff + bit_ff;
   assign ge        = (rem_ff >= trial);
   assign root_next = ge ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);

   always_comb begin
      state_in     = state_ff;
      kr_in        = kr_ff;
      kc_in        = kc_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      acc_r_in     = acc_r_ff;
      acc_i_in     = acc_i_ff;
      rem_in       = rem_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      step_in      = step_ff;
      mag_in       = mag_ff;
      rsp_valid_in = 1'b0;
      tap_en_in    = 1'b0;
      tap_ok_in    = tap_ok;
      pop          = 1'b0;
      fmem_we      = 1'b0;
      kmem_we      = 1'b0;
      if (tap_en_ff && tap_ok_ff) begin
         acc_r_in = acc_r_ff + AW'(prod_r);
         acc_i_in = acc_i_ff + AW'(prod_i);
      end
      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               case (head.kind)
                  ckcm_pkg::KIND_COEF:  kmem_we = 1'b1;
                  ckcm_pkg::KIND_PIXEL: fmem_we = 1'b1;
                  ckcm_pkg::KIND_REQ: begin
                     row_in   = head.row;
                     col_in   = head.col;
                     kr_in    = '0;
                     kc_in    = '0;
                     acc_r_in = '0;
                     acc_i_in = '0;
                     state_in = ST_TAP;
                  end
                  default: pop = 1'b1;
               endcase
            end
         end
         ST_TAP: begin
            tap_en_in = 1'b1;
            if (kc_ff == {cfg.khw, 1'b0}) begin
               kc_in = '0;
               if (kr_ff == {cfg.khh, 1'b0}) begin
                  state_in = ST_DRAIN;
               end else begin
                  kr_in = kr_ff + 1'b1;
               end
            end else begin
               kc_in = kc_ff + 1'b1;
            end
         end
         ST_DRAIN: state_in = ST_SQR;
         ST_SQR: begin
            rem_in   = sq;
            state_in = ST_SQI;
         end
         ST_SQI: begin
            rem_in   = rem_ff + sq;
            res_in   = '0;
            bit_in   = 64'd1 << 62;
            step_in  = 5'd31;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (ge) begin
               rem_in = rem_ff - trial;
            end
            res_in = root_next;
            bit_in = bit_ff >> 2;
            if (step_ff == '0) begin
               rsp_valid_in = 1'b1;
               mag_in       = root_next[31:15];
               state_in     = ST_IDLE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_en_ff    <= tap_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kr_ff     <= kr_in;
      kc_ff     <= kc_in;
      row_ff    <= row_in;
      col_ff    <= col_in;
      acc_r_ff  <= acc_r_in;
      acc_i_ff  <= acc_i_in;
      rem_ff    <= rem_in;
      res_ff    <= res_in;
      bit_ff    <= bit_in;
      step_ff   <= step_in;
      mag_ff    <= mag_in;
      tap_ok_ff <= tap_ok_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_magnitude = mag_ff;
   assign rsp_out_row   = row_ff;
   assign rsp_out_col   = col_ff;

endmodule

[src/complex_kernel_convolution_magnitude.sv]
// Complex-kernel 2-D convolution magnitude.
// Input words arrive on start/busy with req_ fields: opcode 0 writes a kernel
// coefficient, opcode 1 writes a pixel into the frame store, opcode 2 asks for
// the response at (row, col). A word is taken when start is high and busy low.
// Each response appears on the rsp_ ports for exactly one cycle, marked by
// rsp_valid; the receiver cannot stall, so no backpressure exists on that side.
// The csr_ channel writes image width, image height and the two kernel halves;
// csr_ready is always high. The user must make writes only while the block is
// idle; the block itself does not enforce this. The back part stores a pixel
// or coefficient word as it pops it from the queue. A request leaves the queue
// for a tap state over each window tap ((2*khh+1)*(2*khw+1), up to 225 taps
// through a single multiply-accumulate pair), a drain state, a squaring state
// for each part of the sum and the bit-serial square root. The front accepts
// words into a two-entry queue while the back works; busy rises only when full.
// Reset clears the control state and loads the register defaults; the frame
// and kernel stores are not cleared and must be written before they are read.
module complex_kernel_convolution_magnitude #(
   parameter int MAX_COLS        = ckcm_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS        = ckcm_pkg::MAX_ROWS_DEF,
   parameter int MAX_KERNEL_SIDE = ckcm_pkg::MAX_KSIDE_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_opcode,
   input  logic [7:0]          req_row,
   input  logic [7:0]          req_col,
   input  logic [7:0]          req_pixel,
   input  logic signed [15:0]  req_coef_real,
   input  logic signed [15:0]  req_coef_imag,
   output logic                rsp_valid,
   output logic [16:0]         rsp_magnitude,
   output logic [7:0]          rsp_out_row,
   output logic [7:0]          rsp_out_col,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [ckcm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]         csr_data
);

`include "complex_kernel_convolution_magnitude_macros.svh"

   localparam int KH_MAX = (MAX_KERNEL_SIDE - 1) / 2;
   localparam int DW     = ckcm_pkg::DIM_W;

   logic [8:0] width_ff, width_in, height_ff, height_in;
   logic [2:0] khw_ff, khw_in, khh_ff, khh_in;
   ckcm_pkg::cfg_type  cfg;
   ckcm_pkg::item_type head;
   logic head_valid, pop;

   // The register interface never stalls.
   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      khw_in    = khw_ff;
      khh_in    = khh_ff;
      if (csr_valid) begin
         case (csr_index)
            ckcm_pkg::REG_IMAGE_WIDTH:  width_in  = csr_data[8:0];
            ckcm_pkg::REG_IMAGE_HEIGHT: height_in = csr_data[8:0];
            ckcm_pkg::REG_KHALF_WIDTH:  khw_in    = csr_data[2:0];
            ckcm_pkg::REG_KHALF_HEIGHT: khh_in    = csr_data[2:0];
            default: width_in = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
         khw_ff    <= 3'd0;
         khh_ff    <= 3'd0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         khw_ff    <= khw_in;
         khh_ff    <= khh_in;
      end
   end

   // Saturate the image to the store size and the kernel halves to the
   // largest window the kernel store can hold.
   assign cfg.width  = (DW'(width_ff) > DW'(MAX_COLS)) ? DW'(MAX_COLS) : DW'(width_ff);
   assign cfg.height = (DW'(height_ff) > DW'(MAX_ROWS)) ? DW'(MAX_ROWS) : DW'(height_ff);
   assign cfg.khw    = (int'(khw_ff) > KH_MAX) ? 3'(KH_MAX) : khw_ff;
   assign cfg.khh    = (int'(khh_ff) > KH_MAX) ? 3'(KH_MAX) : khh_ff;

   ckcm_front #(
      .MAX_ROWS        (MAX_ROWS),
      .MAX_KERNEL_SIDE (MAX_KERNEL_SIDE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .opcode     (req_opcode),
      .row        (req_row),
      .col        (req_col),
      .pixel      (req_pixel),
      .coef_real  (req_coef_real),
      .coef_imag  (req_coef_imag),
      .cfg        (cfg),
      .max_cols   (DW'(MAX_COLS)),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   ckcm_back #(
      .MAX_COLS        (MAX_COLS),
      .MAX_ROWS        (MAX_ROWS),
      .MAX_KERNEL_SIDE (MAX_KERNEL_SIDE)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .head_valid    (head_valid),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_magnitude (rsp_magnitude),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col)
   );

   // The back part only takes a word the queue really holds.
   `CKCM_ASSERT_SAME(a_pop_has_word, clock, reset, pop, head_valid, "pop from empty queue")
   // A full queue always presents a word at its head.
   `CKCM_ASSERT_SAME(a_busy_has_head, clock, reset, busy, head_valid, "busy with empty queue")
   // A response is a single-cycle strobe.
   `CKCM_ASSERT_NEXT(a_rsp_strobe, clock, reset, rsp_valid, !rsp_valid, "response held")

endmodule
